/* sv/tfv_pkg.sv */
// tfv_pkg: shared types and constants for the text frame validator
// holds the configuration struct, status codes, field offsets and register indexes
// no dependencies
`timescale 1ns / 1ps

package tfv_pkg;

    // byte and status widths
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 3;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // configuration registers as seen by the frame checker
    typedef struct packed {
        t_byte start_byte;
        t_byte end_byte;
        t_byte min_length;
        t_byte max_length;
        t_byte version_expected;
        t_byte version_flag_mask;
        t_byte data_pack_type;
        t_byte protocol_pack_type;
    } t_cfg;

    // register indexes on the configuration port
    localparam t_cfg_idx REG_START_BYTE    = 3'd0;
    localparam t_cfg_idx REG_END_BYTE      = 3'd1;
    localparam t_cfg_idx REG_MIN_LENGTH    = 3'd2;
    localparam t_cfg_idx REG_MAX_LENGTH    = 3'd3;
    localparam t_cfg_idx REG_VERSION_EXP   = 3'd4;
    localparam t_cfg_idx REG_VERSION_MASK  = 3'd5;
    localparam t_cfg_idx REG_DATA_TYPE     = 3'd6;
    localparam t_cfg_idx REG_PROTOCOL_TYPE = 3'd7;

    // register values after reset
    localparam t_byte RST_START_BYTE    = 8'hAA;
    localparam t_byte RST_END_BYTE      = 8'h88;
    localparam t_byte RST_MIN_LENGTH    = 8'd16;
    localparam t_byte RST_MAX_LENGTH    = 8'd255;
    localparam t_byte RST_VERSION_EXP   = 8'd1;
    localparam t_byte RST_VERSION_MASK  = 8'hC0;
    localparam t_byte RST_DATA_TYPE     = 8'd1;
    localparam t_byte RST_PROTOCOL_TYPE = 8'd2;

    // byte offsets of the captured fields
    localparam t_byte POS_HEAD  = 8'd0;
    localparam t_byte POS_LEN   = 8'd1;
    localparam t_byte POS_VER   = 8'd2;
    localparam t_byte POS_CHECK = 8'd4;
    localparam t_byte POS_TYPE  = 8'd14;
    localparam t_byte IDX_FULL  = 8'd255;

    // status codes
    localparam t_status ST_OK    = 3'd0;
    localparam t_status ST_LEN   = 3'd1;
    localparam t_status ST_HEAD  = 3'd2;
    localparam t_status ST_VER   = 3'd3;
    localparam t_status ST_TAIL  = 3'd4;
    localparam t_status ST_TYPE  = 3'd5;
    localparam t_status ST_CHECK = 3'd6;

endpackage

/* sv/tfv_frame.sv */
// tfv_frame: per-frame field capture, running checksum and final judgment
// depends on tfv_pkg for the config struct, offsets and status codes
`timescale 1ns / 1ps

module tfv_frame (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  tfv_pkg::t_byte  i_byte,
    input  logic            i_last,
    input  tfv_pkg::t_cfg   i_cfg,
    output tfv_pkg::t_status o_status
);

    // frame state
    tfv_pkg::t_byte r_byte_index, n_byte_index;
    logic           r_too_long, n_too_long;
    tfv_pkg::t_byte r_running_sum, n_running_sum;
    tfv_pkg::t_byte r_first_byte, n_first_byte;
    tfv_pkg::t_byte r_declared_length, n_declared_length;
    tfv_pkg::t_byte r_version_byte, n_version_byte;
    tfv_pkg::t_byte r_stored_check, n_stored_check;
    tfv_pkg::t_byte r_type_byte, n_type_byte;

    logic rx_len_ok;
    logic decl_len_ok;

    // take one byte into the frame state
    always_comb begin
        n_byte_index      = r_byte_index;
        n_too_long        = r_too_long;
        n_running_sum     = r_running_sum;
        n_first_byte      = r_first_byte;
        n_declared_length = r_declared_length;
        n_version_byte    = r_version_byte;
        n_stored_check    = r_stored_check;
        n_type_byte       = r_type_byte;
        if (r_too_long) begin
            n_too_long = 1'b1;
        end else if (r_byte_index == tfv_pkg::IDX_FULL) begin
            n_too_long = 1'b1;
        end else begin
            n_byte_index = r_byte_index + 8'd1;
            if (r_byte_index == tfv_pkg::POS_HEAD) begin
                n_first_byte  = i_byte;
                n_running_sum = i_byte;
            end else if (r_byte_index == tfv_pkg::POS_LEN) begin
                n_declared_length = i_byte;
                // zero length clears the sum, length one leaves it as is
                if (i_byte == 8'd0) begin
                    n_running_sum = 8'd0;
                end else if (i_byte > 8'd1) begin
                    n_running_sum = r_running_sum + i_byte;
                end
            end else begin
                if (r_byte_index == tfv_pkg::POS_VER) begin
                    n_version_byte = i_byte;
                end
                if (r_byte_index == tfv_pkg::POS_CHECK) begin
                    n_stored_check = i_byte;
                end
                if (r_byte_index == tfv_pkg::POS_TYPE) begin
                    n_type_byte = i_byte;
                end
                if (r_byte_index != tfv_pkg::POS_CHECK &&
                    r_byte_index < r_declared_length) begin
                    n_running_sum = r_running_sum + i_byte;
                end
            end
        end
    end

    // judge the frame as it stands after this byte, first failure wins
    assign rx_len_ok   = (n_byte_index >= i_cfg.min_length) &&
                         (n_byte_index <= i_cfg.max_length);
    assign decl_len_ok = (n_declared_length >= i_cfg.min_length) &&
                         (n_declared_length <= i_cfg.max_length);

    always_comb begin
        if (n_too_long || !rx_len_ok) begin
            o_status = tfv_pkg::ST_LEN;
        end else if (n_first_byte != i_cfg.start_byte) begin
            o_status = tfv_pkg::ST_HEAD;
        end else if (!decl_len_ok) begin
            o_status = tfv_pkg::ST_LEN;
        end else if ((n_version_byte & ~i_cfg.version_flag_mask) != i_cfg.version_expected) begin
            o_status = tfv_pkg::ST_VER;
        end else if (i_byte != i_cfg.end_byte) begin
            o_status = tfv_pkg::ST_TAIL;
        end else if (n_type_byte != i_cfg.data_pack_type &&
                     n_type_byte != i_cfg.protocol_pack_type) begin
            o_status = tfv_pkg::ST_TYPE;
        end else if (n_running_sum != n_stored_check) begin
            o_status = tfv_pkg::ST_CHECK;
        end else begin
            o_status = tfv_pkg::ST_OK;
        end
    end

    // state update, cleared after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_byte_index      <= 8'd0;
            r_too_long        <= 1'b0;
            r_running_sum     <= 8'd0;
            r_first_byte      <= 8'd0;
            r_declared_length <= 8'd0;
            r_version_byte    <= 8'd0;
            r_stored_check    <= 8'd0;
            r_type_byte       <= 8'd0;
        end else if (i_en) begin
            r_byte_index      <= n_byte_index;
            r_too_long        <= n_too_long;
            r_running_sum     <= n_running_sum;
            r_first_byte      <= n_first_byte;
            r_declared_length <= n_declared_length;
            r_version_byte    <= n_version_byte;
            r_stored_check    <= n_stored_check;
            r_type_byte       <= n_type_byte;
        end
    end

    // overflow only ever follows a full index
    a_too_long_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_too_long |-> r_byte_index == tfv_pkg::IDX_FULL)
        else $error("too_long set with index below full");

    // a final byte leaves a clean frame
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_last) |=> (r_byte_index == 8'd0 && !r_too_long && r_running_sum == 8'd0))
        else $error("frame state not cleared after last byte");

    // a middle byte of a short frame advances the index by one
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !i_last && !r_too_long && r_byte_index != tfv_pkg::IDX_FULL)
        |=> r_byte_index == $past(r_byte_index) + 8'd1)
        else $error("byte index did not advance");

endmodule

/* sv/text_frame_validator_unit.sv */
// text_frame_validator_unit: top level, handshake stages and configuration registers
// depends on tfv_pkg and tfv_frame
//
//   channel   direction  signals                                  request
//   in        in         i_in_valid, o_in_stall                   i_data_byte, i_last_byte
//   out       out        o_out_valid, i_out_stall                 o_status (on last byte only)
//   cfg       in         i_cfg_valid, o_cfg_ready                 i_cfg_index, i_cfg_data
//
// one byte per cycle sustained while no final byte waits on a stalled result; a status
// request is presented once the final byte has passed the input register, then the
// result register; the frame checker judges combinationally between those two registers
// synchronous active-low reset clears the frame state and loads register defaults
// a stalled result holds only bytes flagged last; other bytes keep flowing
`timescale 1ns / 1ps

module text_frame_validator_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tfv_pkg::t_byte    i_data_byte,
    input  logic              i_last_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tfv_pkg::t_status  o_status,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  tfv_pkg::t_cfg_idx i_cfg_index,
    input  tfv_pkg::t_byte    i_cfg_data
);

    tfv_pkg::t_cfg    r_cfg;
    logic             r_in_valid;
    tfv_pkg::t_byte   r_in_byte;
    logic             r_in_last;
    logic             r_out_valid;
    tfv_pkg::t_status r_status;
    tfv_pkg::t_status frame_status;
    logic             advance;
    logic             proc_en;
    logic             in_take;
    logic             out_take;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte         <= tfv_pkg::RST_START_BYTE;
            r_cfg.end_byte           <= tfv_pkg::RST_END_BYTE;
            r_cfg.min_length         <= tfv_pkg::RST_MIN_LENGTH;
            r_cfg.max_length         <= tfv_pkg::RST_MAX_LENGTH;
            r_cfg.version_expected   <= tfv_pkg::RST_VERSION_EXP;
            r_cfg.version_flag_mask  <= tfv_pkg::RST_VERSION_MASK;
            r_cfg.data_pack_type     <= tfv_pkg::RST_DATA_TYPE;
            r_cfg.protocol_pack_type <= tfv_pkg::RST_PROTOCOL_TYPE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tfv_pkg::REG_START_BYTE:    r_cfg.start_byte         <= i_cfg_data;
                tfv_pkg::REG_END_BYTE:      r_cfg.end_byte           <= i_cfg_data;
                tfv_pkg::REG_MIN_LENGTH:    r_cfg.min_length         <= i_cfg_data;
                tfv_pkg::REG_MAX_LENGTH:    r_cfg.max_length         <= i_cfg_data;
                tfv_pkg::REG_VERSION_EXP:   r_cfg.version_expected   <= i_cfg_data;
                tfv_pkg::REG_VERSION_MASK:  r_cfg.version_flag_mask  <= i_cfg_data;
                tfv_pkg::REG_DATA_TYPE:     r_cfg.data_pack_type     <= i_cfg_data;
                tfv_pkg::REG_PROTOCOL_TYPE: r_cfg.protocol_pack_type <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // flow control: a staged byte moves on unless it needs the full result slot
    assign out_take   = r_out_valid && !i_out_stall;
    assign advance    = !r_in_last || !r_out_valid || !i_out_stall;
    assign proc_en    = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // frame checker
    tfv_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (proc_en),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_cfg    (r_cfg),
        .o_status (frame_status)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_en && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_en && r_in_last) begin
            r_status <= frame_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

    // a judged final byte always lands in the result register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_en && r_in_last) |=> r_out_valid)
        else $error("final byte processed without a result");

    // upstream only sees a stall while a byte is staged and final
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_in_last && r_out_valid))
        else $error("stall without a pending final byte");

    // a staged byte that is not final never waits
    a_no_wait_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_last) |-> proc_en)
        else $error("middle byte held in input register");

endmodule

/* sim/testbench.sv */
// testbench: self-checking regression for text_frame_validator_unit
// depends on tfv_pkg and the validator rtl; predicts the frame status of each frame and compares
// streams directed and random frames under several register settings and idle patterns
`timescale 1ns / 1ps

module testbench;

    // one received byte as it waits to be sent
    typedef struct {
        tfv_pkg::t_byte data;
        logic           last;
    } t_rx_byte;

    // kinds of damage applied to a generated frame
    typedef enum int {
        FLT_NONE,
        FLT_HEAD,
        FLT_LEN_FIELD,
        FLT_VERSION,
        FLT_TAIL,
        FLT_TYPE,
        FLT_CHECK,
        FLT_NOISE
    } t_fault;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    tfv_pkg::t_byte    i_data_byte = '0;
    logic              i_last_byte = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    tfv_pkg::t_status  o_status;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    tfv_pkg::t_cfg_idx i_cfg_index = tfv_pkg::REG_START_BYTE;
    tfv_pkg::t_byte    i_cfg_data = '0;

    t_rx_byte         frame_bytes[$];
    tfv_pkg::t_status status_due[$];
    logic             in_taken = 1'b0;
    int               send_idle_pct = 0;
    int               stall_pct = 0;
    int               mismatch_count = 0;
    int               phase_budget[8] = '{0, 90, 90, 90, 90, 1, 30, 90};

    // register shadow of the frame checker
    tfv_pkg::t_cfg cfg_shadow = '{tfv_pkg::RST_START_BYTE, tfv_pkg::RST_END_BYTE,
                                  tfv_pkg::RST_MIN_LENGTH, tfv_pkg::RST_MAX_LENGTH,
                                  tfv_pkg::RST_VERSION_EXP, tfv_pkg::RST_VERSION_MASK,
                                  tfv_pkg::RST_DATA_TYPE, tfv_pkg::RST_PROTOCOL_TYPE};

    // frame state of the predictor
    tfv_pkg::t_byte fr_count = '0;
    logic           fr_overflow = 1'b0;
    tfv_pkg::t_byte fr_sum = '0;
    tfv_pkg::t_byte fr_head = '0;
    tfv_pkg::t_byte fr_declared = '0;
    tfv_pkg::t_byte fr_version = '0;
    tfv_pkg::t_byte fr_check = '0;
    tfv_pkg::t_byte fr_type = '0;

    text_frame_validator_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic length_fits(tfv_pkg::t_byte n);
        return n >= cfg_shadow.min_length && n <= cfg_shadow.max_length;
    endfunction

    // capture fields and update the running checksum for one byte
    function automatic void absorb_byte(tfv_pkg::t_byte b);
        if (fr_overflow)
            return;
        if (fr_count == tfv_pkg::IDX_FULL) begin
            fr_overflow = 1'b1;
            return;
        end
        if (fr_count == tfv_pkg::POS_HEAD) begin
            fr_head = b;
            fr_sum = b;
        end else if (fr_count == tfv_pkg::POS_LEN) begin
            fr_declared = b;
            if (b == 8'd0)
                fr_sum = '0;
            else if (b > 8'd1)
                fr_sum = fr_sum + b;
        end else begin
            if (fr_count == tfv_pkg::POS_VER)
                fr_version = b;
            else if (fr_count == tfv_pkg::POS_CHECK)
                fr_check = b;
            else if (fr_count == tfv_pkg::POS_TYPE)
                fr_type = b;
            if (fr_count != tfv_pkg::POS_CHECK && fr_count < fr_declared)
                fr_sum = fr_sum + b;
        end
        fr_count = fr_count + 8'd1;
    endfunction

    // first failing check wins
    function automatic tfv_pkg::t_status grade_frame(tfv_pkg::t_byte tail);
        if (fr_overflow || !length_fits(fr_count))
            return tfv_pkg::ST_LEN;
        if (fr_head != cfg_shadow.start_byte)
            return tfv_pkg::ST_HEAD;
        if (!length_fits(fr_declared))
            return tfv_pkg::ST_LEN;
        if ((fr_version & ~cfg_shadow.version_flag_mask) != cfg_shadow.version_expected)
            return tfv_pkg::ST_VER;
        if (tail != cfg_shadow.end_byte)
            return tfv_pkg::ST_TAIL;
        if (fr_type != cfg_shadow.data_pack_type && fr_type != cfg_shadow.protocol_pack_type)
            return tfv_pkg::ST_TYPE;
        if (fr_sum != fr_check)
            return tfv_pkg::ST_CHECK;
        return tfv_pkg::ST_OK;
    endfunction

    task automatic report_mismatch(string what, tfv_pkg::t_status got,
                                   tfv_pkg::t_status want);
        $display("%0t ns mismatch: %s, status %0d, wanted %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // input driver: present the oldest pending byte, idle at random
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (frame_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid  <= 1'b1;
                i_data_byte <= frame_bytes[0].data;
                i_last_byte <= frame_bytes[0].last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // accepted input request: retire it and predict the frame status
    always @(posedge i_clk) begin
        in_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            void'(frame_bytes.pop_front());
            absorb_byte(i_data_byte);
            if (i_last_byte) begin
                status_due.push_back(grade_frame(i_data_byte));
                fr_count    = '0;
                fr_overflow = 1'b0;
                fr_sum      = '0;
                fr_head     = '0;
                fr_declared = '0;
                fr_version  = '0;
                fr_check    = '0;
                fr_type     = '0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        tfv_pkg::t_status want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_due.size() == 0) begin
                report_mismatch("status with no frame outstanding", o_status, 'x);
            end else begin
                want = status_due.pop_front();
                if (o_status !== want)
                    report_mismatch("frame status", o_status, want);
            end
        end
    end

    task automatic write_reg(tfv_pkg::t_cfg_idx idx, tfv_pkg::t_byte val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            tfv_pkg::REG_START_BYTE:    cfg_shadow.start_byte = val;
            tfv_pkg::REG_END_BYTE:      cfg_shadow.end_byte = val;
            tfv_pkg::REG_MIN_LENGTH:    cfg_shadow.min_length = val;
            tfv_pkg::REG_MAX_LENGTH:    cfg_shadow.max_length = val;
            tfv_pkg::REG_VERSION_EXP:   cfg_shadow.version_expected = val;
            tfv_pkg::REG_VERSION_MASK:  cfg_shadow.version_flag_mask = val;
            tfv_pkg::REG_DATA_TYPE:     cfg_shadow.data_pack_type = val;
            tfv_pkg::REG_PROTOCOL_TYPE: cfg_shadow.protocol_pack_type = val;
            default: ;
        endcase
    endtask

    task automatic load_config(tfv_pkg::t_cfg c);
        write_reg(tfv_pkg::REG_START_BYTE, c.start_byte);
        write_reg(tfv_pkg::REG_END_BYTE, c.end_byte);
        write_reg(tfv_pkg::REG_MIN_LENGTH, c.min_length);
        write_reg(tfv_pkg::REG_MAX_LENGTH, c.max_length);
        write_reg(tfv_pkg::REG_VERSION_EXP, c.version_expected);
        write_reg(tfv_pkg::REG_VERSION_MASK, c.version_flag_mask);
        write_reg(tfv_pkg::REG_DATA_TYPE, c.data_pack_type);
        write_reg(tfv_pkg::REG_PROTOCOL_TYPE, c.protocol_pack_type);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random settings with a narrow length window so frames stay short
    function automatic tfv_pkg::t_cfg random_config();
        tfv_pkg::t_cfg c;
        c = tfv_pkg::t_cfg'({$urandom, $urandom});
        c.min_length = tfv_pkg::t_byte'($urandom_range(1, 20));
        c.max_length = c.min_length + tfv_pkg::t_byte'($urandom_range(0, 60));
        return c;
    endfunction

    function automatic void push_byte(tfv_pkg::t_byte b, logic last);
        t_rx_byte item;
        item.data = b;
        item.last = last;
        frame_bytes.push_back(item);
    endfunction

    // mostly lengths inside the window, some anywhere, a few overlong
    function automatic int pick_length();
        int lo;
        int hi;
        int r;
        r  = $urandom_range(0, 99);
        lo = (cfg_shadow.min_length == 0) ? 1 : cfg_shadow.min_length;
        hi = cfg_shadow.max_length;
        if (hi < lo)
            hi = lo;
        if (hi > lo + 24)
            hi = lo + 24;
        if (r < 3)
            return $urandom_range(256, 290);
        if (r < 12)
            return $urandom_range(1, 255);
        return $urandom_range(lo, hi);
    endfunction

    // build a frame that fits the current settings, then damage it as asked
    task automatic queue_frame(int n, t_fault fault);
        tfv_pkg::t_byte img [0:299];
        tfv_pkg::t_byte sum;
        int             lim;
        for (int i = 0; i < n; i++)
            img[i] = tfv_pkg::t_byte'($urandom);
        if (fault != FLT_NOISE) begin
            img[tfv_pkg::POS_HEAD] = cfg_shadow.start_byte;
            img[tfv_pkg::POS_LEN]  = (n > 255) ? 8'd255 : tfv_pkg::t_byte'(n);
            img[tfv_pkg::POS_VER]  = (cfg_shadow.version_expected
                                      & ~cfg_shadow.version_flag_mask)
                                   | (img[tfv_pkg::POS_VER] & cfg_shadow.version_flag_mask);
            img[tfv_pkg::POS_TYPE] = $urandom_range(0, 1) ? cfg_shadow.data_pack_type
                                                          : cfg_shadow.protocol_pack_type;
            img[n-1] = cfg_shadow.end_byte;
            case (fault)
                FLT_HEAD:
                    img[tfv_pkg::POS_HEAD] ^= tfv_pkg::t_byte'($urandom_range(1, 255));
                FLT_LEN_FIELD: img[tfv_pkg::POS_LEN] = tfv_pkg::t_byte'($urandom);
                FLT_VERSION:   img[tfv_pkg::POS_VER] = tfv_pkg::t_byte'($urandom);
                FLT_TAIL:      img[n-1] ^= tfv_pkg::t_byte'($urandom_range(1, 255));
                FLT_TYPE:      img[tfv_pkg::POS_TYPE] = tfv_pkg::t_byte'($urandom);
                default: ;
            endcase
            // sum over the declared span that was actually received
            lim = img[tfv_pkg::POS_LEN];
            if (lim > n)
                lim = n;
            if (lim > 255)
                lim = 255;
            sum = '0;
            for (int i = 0; i < lim; i++)
                if (i != tfv_pkg::POS_CHECK)
                    sum = sum + img[i];
            img[tfv_pkg::POS_CHECK] = (fault == FLT_CHECK)
                                    ? sum ^ tfv_pkg::t_byte'($urandom_range(1, 255)) : sum;
        end
        for (int i = 0; i < n; i++)
            push_byte(img[i], i == n - 1);
    endtask

    task automatic wait_idle();
        while (frame_bytes.size() != 0 || status_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // stimulus: reset, then one phase per register setting
    initial begin
        tfv_pkg::t_cfg c;
        t_fault        fault;
        int            used;
        int            n;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: c = '{8'hFF, 8'h00, 8'd0, 8'd255, 8'd0, 8'hFF, 8'd0, 8'hFF};
                1: c = '{tfv_pkg::RST_START_BYTE, tfv_pkg::RST_END_BYTE,
                         tfv_pkg::RST_MIN_LENGTH, tfv_pkg::RST_MAX_LENGTH,
                         tfv_pkg::RST_VERSION_EXP, tfv_pkg::RST_VERSION_MASK,
                         tfv_pkg::RST_DATA_TYPE, tfv_pkg::RST_PROTOCOL_TYPE};
                3: begin
                    c = random_config();
                    c.min_length = 8'd0;
                    c.max_length = 8'd255;
                    c.version_flag_mask = 8'h00;
                end
                5: begin
                    c = '{tfv_pkg::RST_START_BYTE, tfv_pkg::RST_END_BYTE, 8'd255, 8'd255,
                          tfv_pkg::RST_VERSION_EXP, tfv_pkg::RST_VERSION_MASK,
                          tfv_pkg::RST_DATA_TYPE, tfv_pkg::RST_PROTOCOL_TYPE};
                end
                6: begin
                    c = random_config();
                    c.min_length = 8'd0;
                    c.max_length = 8'd0;
                end
                default: c = random_config();
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 86; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 86; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            load_config(c);
            @(posedge i_clk);
            if (ph == 0) begin
                // single byte frame, tail is wrong
                push_byte(8'hFF, 1'b1);
                // declared length zero, checksum zero
                push_byte(8'hFF, 1'b0);
                push_byte(8'h00, 1'b1);
                // wrong start byte
                push_byte(8'h00, 1'b0);
                push_byte(8'h00, 1'b1);
                // declared length three, matching the bytes that arrive
                push_byte(8'hFF, 1'b0);
                push_byte(8'h03, 1'b0);
                push_byte(8'h00, 1'b1);
                // declared length one: only the start byte counts
                push_byte(8'hFF, 1'b0);
                push_byte(8'h01, 1'b0);
                push_byte(8'h00, 1'b1);
                queue_frame(16, FLT_NONE);
            end else begin
                // one byte past a full frame
                if (ph == 1)
                    queue_frame(256, FLT_NONE);
                used = 0;
                while (used < phase_budget[ph]) begin
                    n = pick_length();
                    fault = $urandom_range(0, 1) ? FLT_NONE
                                                 : t_fault'($urandom_range(FLT_HEAD, FLT_NOISE));
                    queue_frame(n, fault);
                    used += n;
                end
            end
            wait_idle();
        end
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
sv/tfv_pkg.sv
sv/tfv_frame.sv
sv/text_frame_validator_unit.sv
sim/testbench.sv
